### hdl/sst_pkg.sv
package sst_pkg;

  // fixed field widths
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  // request kinds
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

endpackage

### hdl/sst_if.sv
// request channel: one word per request
interface sst_req_if;
  import sst_pkg::*;
  logic                    valid;
  logic                    ready;
  kind_e                   kind;
  logic signed [KEY_W-1:0] key;
  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

// response channel: one word per request
interface sst_rsp_if;
  import sst_pkg::*;
  logic               valid;
  logic               ready;
  status_e            status;
  logic [COUNT_W-1:0] entry_count;
  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

### hdl/sst_ram.sv
module sst_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/sorted_set_table.sv
// Sorted set table: holds up to CAPACITY distinct signed 32-bit keys in
// ascending order in one single-port-read, single-port-write memory.
// req_i carries one word per request (kind, key): insert, delete, search
// or clear. rsp_o returns one word per request: status and the number of
// keys held after it. Both channels use valid/ready.
// One request is worked at a time. A request walks the table upward from
// entry 0, one memory read per cycle: search stops at the first entry not
// below the key, insert ripples the later entries up by one, delete
// ripples them down by one. The response is formed once the walk ends
// (a clear skips the walk), and the next request is taken after that
// response has gone to the output register.
// The response sits in an output register; a new request is taken while
// an earlier response still waits. If the receiver stalls, a finished
// request holds in the block until the output register frees.
// Reset empties the table (count goes to zero) and drops any pending
// response; memory contents are left as they are.
module sorted_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sst_req_if.sink   req_i,
  sst_rsp_if.source rsp_o
);
  import sst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_END,
    S_INS,
    S_DEL,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  kind_e                   kind_q, kind_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0]        carry_q, carry_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           count_q, count_d;
  status_e                 res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  logic [CW:0]           idx_inc, idx_inc2, count_ext;
  logic                  full, rd_lt, rd_eq;
  logic [CW+COUNT_W-1:0] count_wide;

  sst_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (KEY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // walk pointers and compares against the entry just read
  assign idx_inc    = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_inc2   = {1'b0, idx_q} + (CW+1)'(2);
  assign count_ext  = {1'b0, count_q};
  assign full       = (count_q == CapCnt);
  assign rd_lt      = $signed(ram_rdata) < key_q;
  assign rd_eq      = (ram_rdata == $unsigned(key_q));
  assign count_wide = {{COUNT_W{1'b0}}, count_q};

  // ports
  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;

  // sequencer: next state and memory access
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    key_d        = key_q;
    carry_d      = carry_q;
    idx_d        = idx_q;
    count_d      = count_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[AW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = carry_q;

    // response taken
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d = req_i.kind;
          key_d  = req_i.key;
          idx_d  = '0;
          if (req_i.kind == KIND_CLEAR) begin
            count_d = '0;
            res_d   = ST_OK;
            state_d = S_DONE;
          end else if (count_q == '0) begin
            state_d = S_END;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = S_CMP;
          end
        end
      end

      // ram_rdata holds entry idx
      S_CMP: begin
        if (rd_lt) begin
          idx_d = idx_inc[CW-1:0];
          if (idx_inc == count_ext) begin
            state_d = S_END;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
          end
        end else if (rd_eq) begin
          unique case (kind_q)
            KIND_INSERT: begin
              res_d   = ST_DUP;
              state_d = S_DONE;
            end
            KIND_DELETE: begin
              if (idx_inc == count_ext) begin
                count_d = count_q - CW'(1);
                res_d   = ST_OK;
                state_d = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = idx_inc[AW-1:0];
                state_d   = S_DEL;
              end
            end
            default: begin
              res_d   = ST_OK;
              state_d = S_DONE;
            end
          endcase
        end else if (kind_q == KIND_INSERT) begin
          if (full) begin
            res_d   = ST_FULL;
            state_d = S_DONE;
          end else begin
            // key goes here, old entry is carried up
            ram_we    = 1'b1;
            ram_wdata = key_q;
            carry_d   = ram_rdata;
            idx_d     = idx_inc[CW-1:0];
            if (idx_inc < count_ext) begin
              ram_re    = 1'b1;
              ram_raddr = idx_inc[AW-1:0];
            end
            state_d = S_INS;
          end
        end else begin
          res_d   = ST_ABSENT;
          state_d = S_DONE;
        end
      end

      // key above every entry held
      S_END: begin
        if (kind_q == KIND_INSERT) begin
          if (full) begin
            res_d = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = key_q;
            count_d   = count_q + CW'(1);
            res_d     = ST_OK;
          end
        end else begin
          res_d = ST_ABSENT;
        end
        state_d = S_DONE;
      end

      // ripple up: write carried entry, pick up the one it displaces
      S_INS: begin
        ram_we    = 1'b1;
        ram_wdata = carry_q;
        if (idx_q == count_q) begin
          count_d = count_q + CW'(1);
          res_d   = ST_OK;
          state_d = S_DONE;
        end else begin
          carry_d = ram_rdata;
          idx_d   = idx_inc[CW-1:0];
          if (idx_inc < count_ext) begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
          end
        end
      end

      // ripple down: ram_rdata holds entry idx + 1
      S_DEL: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_d     = idx_inc[CW-1:0];
        if (idx_inc2 == count_ext) begin
          count_d = count_q - CW'(1);
          res_d   = ST_OK;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc2[AW-1:0];
        end
      end

      // hand the word to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_count_d  = count_wide[COUNT_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_INSERT;
      key_q        <= '0;
      carry_q      <= '0;
      idx_q        <= '0;
      count_q      <= '0;
      res_q        <= ST_OK;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      key_q        <= key_d;
      carry_q      <= carry_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
    end
  end

endmodule
